FILE: sv/nfba_pkg.sv
// Package for the next-fit bitmap allocator.
// Holds field widths, default sizes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package nfba_pkg;

  localparam int unsigned MapBitsDef  = 4096;
  localparam int unsigned WordBitsDef = 64;

  localparam int unsigned LenW     = 13;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned WidxW    = 6;
  localparam int unsigned WvalW    = 64;
  localparam int unsigned StartW   = 12;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 16;

  localparam logic [CfgW-1:0] BitsInUseRst = 13'd4096;

  localparam int unsigned LenLsb  = 0;
  localparam int unsigned WidxLsb = LenLsb + LenW;
  localparam int unsigned WvalLsb = WidxLsb + WidxW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESP
  } nfba_state_e;

  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic word_wr;
    logic start_pass1;
    logic start_pass2;
    logic rd;
    logic eval;
    logic mark_wr;
    logic res_fail;
    logic res_write;
    logic res_alloc;
    logic out_load;
  } nfba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_kind;
    logic in_len_zero;
    logic w_in_range;
    logic pass2;
    logic match;
    logic mark_last;
    logic out_busy;
  } nfba_sts_t;

endpackage

FILE: sv/next_fit_bitmap_allocator.sv
// Next-fit bitmap allocator, top level: controller plus datapath.
// Depends on nfba_pkg, nfba_ctrl and nfba_dpath.
//
// Takes one request at a time. A word write is done in the idle state and then answered. An
// allocation scans the bitmap words from the hint, then from word 0; each bitmap word is read and
// then evaluated through the single memory port, and the found run is marked with a
// read-modify-write per word.
// After reset a clearing pass over all MAP_BITS / WORD_BITS words runs before the
// first request is taken; configuration writes are taken at any time.
module next_fit_bitmap_allocator
  import nfba_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MapBitsDef,
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0: request_length[12:0], word_index[18:13], word_value[82:19].
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: kind.
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Fields from bit 0: ok[0], start_bit[12:1].
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  nfba_cmd_t cmd;
  nfba_sts_t sts;

  nfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nfba_dpath #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tdata_o (m_axis_tdata_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("Input was accepted while a request was still in work.");

  a_fail_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[12:1] == '0))
    else $error("A failed result carries a nonzero start bit.");

endmodule

FILE: sv/nfba_ctrl.sv
// Controller state machine of the next-fit bitmap allocator.
// Depends on nfba_pkg; drives the datapath only through command and status structs.
module nfba_ctrl
  import nfba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nfba_sts_t sts_i,
  output nfba_cmd_t cmd_o
);

  nfba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.in_kind) begin
            cmd_o.word_wr   = 1'b1;
            cmd_o.res_write = 1'b1;
            state_d         = ST_RESP;
          end else if (sts_i.in_len_zero) begin
            cmd_o.res_fail = 1'b1;
            state_d        = ST_RESP;
          end else begin
            cmd_o.start_pass1 = 1'b1;
            state_d           = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.w_in_range) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_EVAL;
        end else if (!sts_i.pass2) begin
          cmd_o.start_pass2 = 1'b1;
        end else begin
          cmd_o.res_fail = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.match ? ST_MARK_RD : ST_CHECK;
      end
      ST_MARK_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        cmd_o.mark_wr = 1'b1;
        if (sts_i.mark_last) begin
          cmd_o.res_alloc = 1'b1;
          state_d         = ST_RESP;
        end else begin
          state_d = ST_MARK_RD;
        end
      end
      ST_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: sv/nfba_dpath.sv
// Datapath of the next-fit bitmap allocator: bitmap memory, word scanner,
// run marker, hint and the output register. Depends on nfba_pkg.
module nfba_dpath
  import nfba_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MapBitsDef,
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nfba_cmd_t           cmd_i,
  output nfba_sts_t           sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic [InDataW-1:0]  in_tdata_i,
  input  logic                in_tuser_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_tdata_o
);

  localparam int unsigned NumWords = MAP_BITS / WORD_BITS;
  localparam int unsigned AW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned CW = $clog2(NumWords + 1);
  localparam int unsigned BW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mem_q [NumWords];
  logic [WORD_BITS-1:0] rdata_q;

  logic [CW-1:0]        w_q, hint_word_q, match_w_q;
  logic                 pass2_q;
  logic [LenW-1:0]      len_q, carry_q, rem_q;
  logic [BW-1:0]        match_j_q, hi_q;
  logic [CfgW-1:0]      bits_in_use_q;
  logic                 res_ok_q, out_valid_q;
  logic [StartW-1:0]    res_start_q, out_start_q;
  logic                 out_ok_q;

  logic [LenW-1:0]      in_len;
  logic [WidxW-1:0]     in_widx;
  logic [WORD_BITS-1:0] in_wval;
  logic                 widx_ok;

  assign in_len  = in_tdata_i[LenLsb +: LenW];
  assign in_widx = in_tdata_i[WidxLsb +: WidxW];
  assign in_wval = in_tdata_i[WvalLsb +: WORD_BITS];
  assign widx_ok = 32'(in_widx) < NumWords;

  logic [31:0] size_bits, w_end;
  assign size_bits = (32'(bits_in_use_q) > MAP_BITS) ? MAP_BITS : 32'(bits_in_use_q);
  assign w_end     = (32'(w_q) + 32'd1) * WORD_BITS;

  logic [WORD_BITS-1:0] free_v, lt_v, cond_v;
  logic                 found, any_used;
  logic [BW-1:0]        j_sel, u_sel;
  logic [LenW-1:0]      carry_nxt;

  always_comb begin
    logic wf;
    wf = 1'b0;
    for (int b = 0; b < WORD_BITS; b++) begin
      free_v[b] = !rdata_q[WORD_BITS-1-b];
      lt_v[b]   = 32'(b) < 32'(len_q);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      wf = 1'b1;
      for (int k = 0; k <= j; k++) begin
        wf = wf & (free_v[k] | !lt_v[j-k]);
      end
      cond_v[j] = wf && ((32'(carry_q) + 32'(j) + 32'd1) >= 32'(len_q));
    end
    found = 1'b0;
    j_sel = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cond_v[j]) begin
        found = 1'b1;
        j_sel = BW'(j);
      end
    end
    any_used = 1'b0;
    u_sel    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!free_v[b]) begin
        any_used = 1'b1;
        u_sel    = BW'(b);
      end
    end
    carry_nxt = any_used ? LenW'(32'(WORD_BITS - 1) - 32'(u_sel))
                         : LenW'(32'(carry_q) + WORD_BITS);
  end

  logic                 mark_last;
  logic [BW-1:0]        lo_b;
  logic [WORD_BITS-1:0] mask_v;

  assign mark_last = (32'(hi_q) + 32'd1) >= 32'(rem_q);
  assign lo_b      = mark_last ? BW'(32'(hi_q) + 32'd1 - 32'(rem_q)) : '0;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask_v[WORD_BITS-1-b] = (BW'(b) >= lo_b) && (BW'(b) <= hi_q);
    end
  end

  logic                 we;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;

  always_comb begin
    we = 1'b0;
    wa = w_q[AW-1:0];
    wd = '0;
    priority if (cmd_i.clear_wr) begin
      we = 1'b1;
    end else if (cmd_i.word_wr) begin
      we = widx_ok;
      wa = AW'(in_widx);
      wd = in_wval;
    end else if (cmd_i.mark_wr) begin
      we = 1'b1;
      wd = rdata_q | mask_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[w_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q           <= '0;
      hint_word_q   <= '0;
      pass2_q       <= 1'b0;
      bits_in_use_q <= BitsInUseRst;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bits_in_use_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_wr) begin
        w_q <= w_q + CW'(1);
      end
      if (cmd_i.start_pass1) begin
        w_q     <= hint_word_q;
        pass2_q <= 1'b0;
      end
      if (cmd_i.start_pass2) begin
        w_q     <= '0;
        pass2_q <= 1'b1;
      end
      if (cmd_i.eval && !found) begin
        w_q <= w_q + CW'(1);
      end
      if (cmd_i.mark_wr && !mark_last) begin
        w_q <= w_q - CW'(1);
      end
      if (cmd_i.res_alloc) begin
        hint_word_q <= match_w_q + CW'(match_j_q == BW'(WORD_BITS - 1));
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      len_q <= in_len;
    end
    if (cmd_i.start_pass1 || cmd_i.start_pass2) begin
      carry_q <= '0;
    end
    if (cmd_i.eval) begin
      if (found) begin
        match_w_q <= w_q;
        match_j_q <= j_sel;
        hi_q      <= j_sel;
        rem_q     <= len_q;
      end else begin
        carry_q <= carry_nxt;
      end
    end
    if (cmd_i.mark_wr) begin
      rem_q <= LenW'(32'(rem_q) - 32'(hi_q) - 32'd1);
      hi_q  <= BW'(WORD_BITS - 1);
    end
    if (cmd_i.res_fail) begin
      res_ok_q    <= 1'b0;
      res_start_q <= '0;
    end
    if (cmd_i.res_write) begin
      res_ok_q    <= widx_ok;
      res_start_q <= '0;
    end
    if (cmd_i.res_alloc) begin
      res_ok_q    <= 1'b1;
      res_start_q <= StartW'(32'(match_w_q) * WORD_BITS + 32'(match_j_q) + 32'd1
                             - 32'(len_q));
    end
    if (cmd_i.out_load) begin
      out_ok_q    <= res_ok_q;
      out_start_q <= res_start_q;
    end
  end

  always_comb begin
    sts_o.clear_last  = 32'(w_q) == (NumWords - 1);
    sts_o.in_kind     = in_tuser_i;
    sts_o.in_len_zero = in_len == '0;
    sts_o.w_in_range  = (w_end <= size_bits) && (!pass2_q || (w_q < hint_word_q));
    sts_o.pass2       = pass2_q;
    sts_o.match       = found;
    sts_o.mark_last   = mark_last;
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {(OutDataW - StartW - 1)'(0), out_start_q, out_ok_q};

endmodule

FILE: bench/next_fit_bitmap_allocator_test.sv
// Self-checking bench for the next-fit bitmap allocator.
// Drives allocate and word-write transfers, predicts each result, compares them.
// Depends on nfba_pkg and next_fit_bitmap_allocator.
module next_fit_bitmap_allocator_test;
  import nfba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumWords = MapBitsDef / WordBitsDef;
  localparam logic KindAlloc = 1'b0;
  localparam logic KindWrite = 1'b1;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic             kind;
    logic [LenW-1:0]  len;
    logic [WidxW-1:0] widx;
    logic [WvalW-1:0] wval;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [StartW-1:0] start;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  next_fit_bitmap_allocator uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [WvalW-1:0] occ_map [NumWords];
  logic [CfgW:0] model_hint;
  logic [CfgW-1:0] model_size;
  req_t pending_reqs[$];
  resp_t expected_resps[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_send = 1'b0;

  function automatic bit is_used(int unsigned idx);
    return occ_map[idx / WordBitsDef][WordBitsDef - 1 - (idx % WordBitsDef)];
  endfunction

  function automatic bit find_run(int unsigned first, int unsigned last, int unsigned len,
                                  output int unsigned start);
    int unsigned run;
    run = 0;
    start = 0;
    if (first >= last) return 1'b0;
    for (int unsigned i = first * WordBitsDef; i < last * WordBitsDef; i++) begin
      if (is_used(i)) begin
        run = 0;
      end else begin
        run++;
        if (run == len) begin
          start = i + 1 - len;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic resp_t allocate_predict(req_t r);
    resp_t res;
    int unsigned size, words, hword, start;
    bit found;
    res = '0;
    if (r.kind == KindWrite) begin
      occ_map[r.widx] = r.wval;
      res.ok = 1'b1;
      return res;
    end
    if (r.len == 0) return res;
    size = (model_size > MapBitsDef) ? MapBitsDef : model_size;
    words = size / WordBitsDef;
    hword = model_hint / WordBitsDef;
    found = find_run(hword, words, r.len, start);
    if (!found) found = find_run(0, (hword < words) ? hword : words, r.len, start);
    if (found) begin
      for (int unsigned i = start; i < start + r.len; i++)
        occ_map[i / WordBitsDef][WordBitsDef - 1 - (i % WordBitsDef)] = 1'b1;
      model_hint = (CfgW + 1)'(start + r.len);
      res.ok = 1'b1;
      res.start = start[StartW-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      expected_resps.push_back(allocate_predict(
          {s_axis_tuser_i, s_axis_tdata_i[LenLsb +: LenW], s_axis_tdata_i[WidxLsb +: WidxW],
           s_axis_tdata_i[WvalLsb +: WvalW]}));
    end
    if (!(s_axis_tvalid_i && s_axis_tready_o) || s_axis_tvalid_i) begin
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_reqs.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 34)) begin
          req_t r;
          r = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= r.kind;
          s_axis_tdata_i <= {5'b0, r.wval, r.widx, r.len};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    resp_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.ok = m_axis_tdata_o[0];
      got.start = m_axis_tdata_o[StartW:1];
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer ok=%0d start=%0d", got.ok, got.start);
      end else begin
        want = expected_resps.pop_front();
        if (got.ok !== want.ok || got.start !== want.start) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected ok=%0d start=%0d, actual ok=%0d start=%0d",
                     want.ok, want.start, got.ok, got.start);
        end
      end
    end
    m_axis_tready_i <= calm || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_resps.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_size(logic [CfgW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    model_size = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_req(logic kind, logic [LenW-1:0] len, logic [WidxW-1:0] widx,
                         logic [WvalW-1:0] wval);
    pending_reqs.push_back({kind, len, widx, wval});
  endtask

  task automatic add_random(int unsigned count);
    logic [WvalW-1:0] v;
    for (int unsigned i = 0; i < count; i++) begin
      v = {$urandom, $urandom};
      case ($urandom_range(9))
        0: v = '0;
        1: v = v & {$urandom, $urandom};
        2: v = '1;
        default: ;
      endcase
      if ($urandom_range(3) == 0)
        add_req(KindWrite, LenW'($urandom), WidxW'($urandom), v);
      else if ($urandom_range(19) == 0)
        add_req(KindAlloc, LenW'($urandom), WidxW'($urandom), v);
      else
        add_req(KindAlloc, LenW'($urandom_range(($urandom_range(9) == 0) ? 300 : 40)),
                WidxW'($urandom), v);
    end
  endtask

  initial begin
    logic [CfgW-1:0] sizes [6];
    foreach (occ_map[i]) occ_map[i] = '0;
    model_hint = '0;
    model_size = BitsInUseRst;
    sizes = '{13'd4096, 13'd0, 13'd8191, 13'd100, 13'd1024, 13'd4095};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_req(KindAlloc, 13'd0, 6'd0, '0);
    add_req(KindAlloc, 13'd1, 6'd63, '1);
    add_req(KindAlloc, 13'd64, 6'd0, '0);
    add_req(KindAlloc, 13'd100, 6'd0, '0);
    add_req(KindAlloc, 13'd4096, 6'd0, '0);
    add_req(KindAlloc, 13'd8191, 6'd0, '0);
    add_req(KindWrite, 13'd0, 6'd0, '0);
    add_req(KindWrite, 13'd0, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(KindWrite, 13'd8191, 6'd1, 64'h8000_0000_0000_0001);
    add_req(KindAlloc, 13'd4000, 6'd0, '0);
    add_req(KindAlloc, 13'd3, 6'd0, '0);
    add_req(KindWrite, 13'd0, 6'd5, 64'h0);
    add_req(KindAlloc, 13'd4096, 6'd0, '0);
    add_req(KindAlloc, 13'd1, 6'd0, '0);
    wait_drained();
    hold_send = 1'b1;
    add_random(40);
    repeat (50) @(posedge clk_i);
    hold_send = 1'b0;
    for (int s = 0; s < 6; s++) begin
      wait_drained();
      set_size(sizes[s]);
      for (int w = 0; w < NumWords; w++)
        if ($urandom_range(2) == 0) add_req(KindWrite, '0, WidxW'(w), '0);
      calm = (s == 2);
      add_random(200);
    end
    wait_drained();
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/nfba_pkg.sv
sv/nfba_ctrl.sv
sv/nfba_dpath.sv
sv/next_fit_bitmap_allocator.sv
bench/next_fit_bitmap_allocator_test.sv
